// ----- rtl/wrht_pkg.sv -----
// Shared types and constants for the window region hit test block.
package wrht_pkg;

	// Window-relative coordinate width: 17-bit difference plus headroom
	localparam int CoordW = 18;
	typedef logic signed [CoordW-1:0] coord_t;

	// Stream widths
	localparam int InDataW  = 96;
	localparam int InUserW  = 5;
	localparam int OutDataW = 8;

	// Configuration port widths
	localparam int CfgIdxW  = 8;
	localparam int CfgDataW = 8;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_FRAME_W   = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_CAPTION_H = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_BTN_SIDE  = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_BTN_GAP   = 8'd3;

	// Reset values of the configuration registers
	localparam logic [3:0] FRAME_W_RST   = 4'd4;
	localparam logic [5:0] CAPTION_H_RST = 6'd24;
	localparam logic [5:0] BTN_SIDE_RST  = 6'd16;
	localparam logic [3:0] BTN_GAP_RST   = 4'd4;

	// Region codes
	typedef enum logic [3:0] {
		RG_NOWHERE     = 4'd0,
		RG_CLIENT      = 4'd1,
		RG_CAPTION     = 4'd2,
		RG_CLOSE       = 4'd3,
		RG_MAXIMIZE    = 4'd4,
		RG_MINIMIZE    = 4'd5,
		RG_LEFT        = 4'd6,
		RG_RIGHT       = 4'd7,
		RG_TOP         = 4'd8,
		RG_BOTTOM      = 4'd9,
		RG_TOPLEFT     = 4'd10,
		RG_TOPRIGHT    = 4'd11,
		RG_BOTTOMLEFT  = 4'd12,
		RG_BOTTOMRIGHT = 4'd13
	} region_t;

	// Frame geometry settings
	typedef struct packed {
		logic [3:0] frame_w;
		logic [5:0] caption_h;
		logic [5:0] btn_side;
		logic [3:0] btn_gap;
	} geom_cfg_t;

	// One query
	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] window_left;
		logic signed [15:0] window_top;
		logic [14:0]        outer_width;
		logic [14:0]        outer_height;
		logic               window_valid;
		logic               has_caption;
		logic               has_maximize_box;
		logic               has_minimize_box;
		logic               has_resize_frame;
	} query_t;

endpackage

// ----- rtl/wrht_cfg_regs.sv -----
// Geometry configuration registers written through the configuration channel.
module wrht_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [wrht_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [wrht_pkg::CfgDataW-1:0] cfg_data,
	output wrht_pkg::geom_cfg_t      geom
);
	import wrht_pkg::*;

	geom_cfg_t geom_q;

	// Always able to take a write
	assign cfg_ready = 1'b1;
	assign geom      = geom_q;

	// Update the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.frame_w   <= FRAME_W_RST;
			geom_q.caption_h <= CAPTION_H_RST;
			geom_q.btn_side  <= BTN_SIDE_RST;
			geom_q.btn_gap   <= BTN_GAP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_W:   geom_q.frame_w   <= cfg_data[3:0];
				REG_CAPTION_H: geom_q.caption_h <= cfg_data[5:0];
				REG_BTN_SIDE:  geom_q.btn_side  <= cfg_data[5:0];
				REG_BTN_GAP:   geom_q.btn_gap   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/wrht_classify.sv -----
// Combinational classification of one query into a region code.
module wrht_classify (
	input  wrht_pkg::query_t    query,
	input  wrht_pkg::geom_cfg_t geom,
	output wrht_pkg::region_t   region
);
	import wrht_pkg::*;

	coord_t wx, wy, fw, fh, bw, th, bs, bm;
	coord_t diff, diff_adj, half, by0, step, cx, mx, nx, right_e, bottom_e;
	logic   in_window, in_caption, in_btn_row, hit_close, hit_max, hit_min;

	// Window-relative point and extended operands
	always_comb begin
		wx = coord_t'(query.point_x) - coord_t'(query.window_left);
		wy = coord_t'(query.point_y) - coord_t'(query.window_top);
		fw = coord_t'({1'b0, query.outer_width});
		fh = coord_t'({1'b0, query.outer_height});
		bw = coord_t'({1'b0, geom.frame_w});
		th = coord_t'({1'b0, geom.caption_h});
		bs = coord_t'({1'b0, geom.btn_side});
		bm = coord_t'({1'b0, geom.btn_gap});
	end

	// Caption and button geometry; halve toward zero
	always_comb begin
		diff     = th - bs;
		diff_adj = diff + coord_t'({1'b0, diff[CoordW-1]});
		half     = diff_adj >>> 1;
		by0      = bw + half;
		step     = bs + bm;
		cx       = fw - bw - step;
		mx       = cx - step;
		nx       = mx - step;
		right_e  = fw - bw;
		bottom_e = fh - bw;
	end

	// Range tests
	always_comb begin
		in_window  = query.window_valid && (wx >= 0) && (wy >= 0) && (wx < fw) && (wy < fh);
		in_caption = query.has_caption && (wy >= bw) && (wy < bw + th);
		in_btn_row = (wy >= by0) && (wy < by0 + bs);
		hit_close  = (wx >= cx) && (wx < cx + bs);
		hit_max    = query.has_maximize_box && (wx >= mx) && (wx < mx + bs);
		hit_min    = query.has_minimize_box && (wx >= nx) && (wx < nx + bs);
	end

	// Priority selection of the region
	always_comb begin
		region = RG_CLIENT;
		if (!in_window) begin
			region = RG_NOWHERE;
		end else if (in_caption) begin
			if (in_btn_row && hit_close)
				region = RG_CLOSE;
			else if (in_btn_row && hit_max)
				region = RG_MAXIMIZE;
			else if (in_btn_row && hit_min)
				region = RG_MINIMIZE;
			else
				region = RG_CAPTION;
		end else if (query.has_resize_frame) begin
			if (wx < bw) begin
				if (wy < bw)            region = RG_TOPLEFT;
				else if (wy >= bottom_e) region = RG_BOTTOMLEFT;
				else                     region = RG_LEFT;
			end else if (wx >= right_e) begin
				if (wy < bw)            region = RG_TOPRIGHT;
				else if (wy >= bottom_e) region = RG_BOTTOMRIGHT;
				else                     region = RG_RIGHT;
			end else if (wy < bw) begin
				region = RG_TOP;
			end else if (wy >= bottom_e) begin
				region = RG_BOTTOM;
			end
		end
	end

endmodule

// ----- rtl/window_region_hit_test.sv -----
// Window region hit test: input register, classifier and result register.
//
// Usage: each transaction on the s_ channel is one query: a screen point,
// the outer rectangle of a window and its style flags (window_valid,
// caption, maximize box, minimize box, resize frame in s_tuser). The block
// answers with one region code per query on the m_ channel, in order.
// Frame, caption and button sizes come from four registers written on the
// cfg_ channel (index 0 border width, 1 caption height, 2 button size,
// 3 button margin); other indexes are ignored. Write them only when idle.
// The input register takes the query at the accepting edge; the result
// register loads from it when it is empty or being emptied, raising m_tvalid.
// One query per cycle while m_tready is high, set by the two-stage pipeline.
// Reset clears both stage valids and loads the default geometry
// (4, 24, 16, 4). When the receiver holds m_tready low the result stays
// put, the input register fills behind it, and s_tready then drops until
// the result is taken.
module window_region_hit_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// point_x[15:0], point_y[31:16], window_left[47:32], window_top[63:48],
	// outer_width[78:64], outer_height[93:79], zero[95:94]
	input  logic [wrht_pkg::InDataW-1:0]  s_tdata,
	// window_valid[0], has_caption[1], has_maximize_box[2],
	// has_minimize_box[3], has_resize_frame[4]
	input  logic [wrht_pkg::InUserW-1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// region[3:0], zero[7:4]
	output logic [wrht_pkg::OutDataW-1:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [wrht_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [wrht_pkg::CfgDataW-1:0] cfg_data
);
	import wrht_pkg::*;

	geom_cfg_t geom;
	query_t    query_in, query_s1;
	region_t   region_c, region_s2;
	logic      valid_s1, valid_s2;
	logic      adv_s2;

	wrht_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	// Unpack the incoming transaction
	always_comb begin
		query_in.point_x          = s_tdata[15:0];
		query_in.point_y          = s_tdata[31:16];
		query_in.window_left      = s_tdata[47:32];
		query_in.window_top       = s_tdata[63:48];
		query_in.outer_width      = s_tdata[78:64];
		query_in.outer_height     = s_tdata[93:79];
		query_in.window_valid     = s_tuser[0];
		query_in.has_caption      = s_tuser[1];
		query_in.has_maximize_box = s_tuser[2];
		query_in.has_minimize_box = s_tuser[3];
		query_in.has_resize_frame = s_tuser[4];
	end

	// Advance when the result register is empty or being emptied
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Capture the query
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			query_s1 <= query_in;
	end

	wrht_classify u_classify (
		.query  (query_s1),
		.geom   (geom),
		.region (region_c)
	);

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1)
			region_s2 <= region_c;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, region_s2};

endmodule

// ----- verif/window_region_hit_test_checker.sv -----
// Checker for the window region hit test: predicts each region code and compares it.
`timescale 1ns / 1ps

module window_region_hit_test_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic [4:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          outstanding
);
	import wrht_pkg::*;

	geom_cfg_t geom;
	region_t   expected_regions[$];

	// Work out the region of one query under the given frame geometry
	function automatic region_t classify_region(input logic [95:0] data,
	                                            input logic [4:0] user,
	                                            input geom_cfg_t g);
		query_t q;
		int wx, wy, fw, fh, bw, th, bs, bm;
		int half_gap, row0, step, close_x, max_x, min_x, right_band, bottom_band;
		q.point_x          = data[15:0];
		q.point_y          = data[31:16];
		q.window_left      = data[47:32];
		q.window_top       = data[63:48];
		q.outer_width      = data[78:64];
		q.outer_height     = data[93:79];
		q.window_valid     = user[0];
		q.has_caption      = user[1];
		q.has_maximize_box = user[2];
		q.has_minimize_box = user[3];
		q.has_resize_frame = user[4];

		if (!q.window_valid)
			return RG_NOWHERE;

		// Window-relative point, exact in int
		wx = int'($signed(q.point_x)) - int'($signed(q.window_left));
		wy = int'($signed(q.point_y)) - int'($signed(q.window_top));
		fw = int'(q.outer_width);
		fh = int'(q.outer_height);
		if (wx < 0 || wy < 0 || wx >= fw || wy >= fh)
			return RG_NOWHERE;

		bw = int'(g.frame_w);
		th = int'(g.caption_h);
		bs = int'(g.btn_side);
		bm = int'(g.btn_gap);

		// Caption rows, with the button row centred in them
		if (q.has_caption && wy >= bw && wy < bw + th) begin
			// int division truncates toward zero, also for a negative gap
			half_gap = (th - bs) / 2;
			row0 = bw + half_gap;
			if (wy >= row0 && wy < row0 + bs) begin
				step = bs + bm;
				close_x = fw - bw - step;
				if (wx >= close_x && wx < close_x + bs)
					return RG_CLOSE;
				max_x = close_x - step;
				if (q.has_maximize_box && wx >= max_x && wx < max_x + bs)
					return RG_MAXIMIZE;
				min_x = max_x - step;
				if (q.has_minimize_box && wx >= min_x && wx < min_x + bs)
					return RG_MINIMIZE;
			end
			return RG_CAPTION;
		end

		// Resize bands: left wins over right, top over bottom
		if (q.has_resize_frame) begin
			right_band = fw - bw;
			bottom_band = fh - bw;
			if (wx < bw) begin
				if (wy < bw)
					return RG_TOPLEFT;
				if (wy >= bottom_band)
					return RG_BOTTOMLEFT;
				return RG_LEFT;
			end
			if (wx >= right_band) begin
				if (wy < bw)
					return RG_TOPRIGHT;
				if (wy >= bottom_band)
					return RG_BOTTOMRIGHT;
				return RG_RIGHT;
			end
			if (wy < bw)
				return RG_TOP;
			if (wy >= bottom_band)
				return RG_BOTTOM;
		end

		return RG_CLIENT;
	endfunction

	// Track geometry, queue predictions and compare results in order
	always @(posedge clk or negedge arst_n) begin
		region_t got;
		region_t want;
		if (!arst_n) begin
			geom.frame_w   <= FRAME_W_RST;
			geom.caption_h <= CAPTION_H_RST;
			geom.btn_side  <= BTN_SIDE_RST;
			geom.btn_gap   <= BTN_GAP_RST;
			expected_regions.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// Register writes; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_W:   geom.frame_w   <= cfg_data[3:0];
					REG_CAPTION_H: geom.caption_h <= cfg_data[5:0];
					REG_BTN_SIDE:  geom.btn_side  <= cfg_data[5:0];
					REG_BTN_GAP:   geom.btn_gap   <= cfg_data[3:0];
					default: ;
				endcase
			end

			// Result transaction: check against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = region_t'(m_tdata[3:0]);
				if (expected_regions.size() == 0) begin
					$error("region: unexpected result %0d with nothing pending", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_regions.pop_front();
					if (got !== want) begin
						$error("region: expected %0d, actual %0d", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end

			// Query transaction: predict its region
			if (s_tvalid && s_tready)
				expected_regions.push_back(classify_region(s_tdata, s_tuser, geom));

			outstanding <= expected_regions.size();
		end
	end

endmodule

// ----- verif/window_region_hit_test_tb.sv -----
// Top of the window region hit test bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module window_region_hit_test_tb;
	import wrht_pkg::*;

	// Style flag masks as carried in s_tuser
	localparam logic [4:0] FL_VALID    = 5'b00001;
	localparam logic [4:0] FL_CAPTION  = 5'b00010;
	localparam logic [4:0] FL_MAXIMIZE = 5'b00100;
	localparam logic [4:0] FL_MINIMIZE = 5'b01000;
	localparam logic [4:0] FL_RESIZE   = 5'b10000;
	localparam logic [4:0] FL_ALL      = 5'b11111;

	// Index with no register behind it
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 8'd200;

	localparam int PhaseItems = 85;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [4:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;
	int          fail_count;
	int          outstanding;

	geom_cfg_t cur_geom;
	bit        gapless_sender;

	always #5 clk = ~clk;

	window_region_hit_test u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	window_region_hit_test_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offset along one axis, biased to the borders and the given band
	function automatic int pick_offset(input int extent, input int band_lo,
	                                   input int band_hi, input int bw);
		int lo, hi;
		case ($urandom_range(0, 3))
			0: begin
				lo = -2;
				hi = extent + 1;
			end
			1: begin
				lo = -2;
				hi = bw + 2;
			end
			2: begin
				lo = extent - bw - 2;
				hi = extent + 1;
			end
			default: begin
				lo = band_lo;
				hi = band_hi;
			end
		endcase
		if (hi < lo)
			hi = lo;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Offer one query after an optional gap and hold it until taken
	task automatic send_query(input logic [95:0] data, input logic [4:0] flags);
		int gap;
		gap = gapless_sender ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= data;
		s_tuser  <= flags;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Query at an offset from the window's top-left corner
	task automatic send_offset(input int left, input int top, input int w, input int h,
	                           input int dx, input int dy, input logic [4:0] flags);
		logic [15:0] px, py, lx, ty;
		logic [14:0] ow, oh;
		px = 16'(left + dx);
		py = 16'(top + dy);
		lx = 16'(left);
		ty = 16'(top);
		ow = 15'(w);
		oh = 15'(h);
		send_query({2'b00, oh, ow, ty, lx, py, px}, flags);
	endtask

	// Well-formed query aimed at frame, caption and buttons, with some noise
	task automatic send_random_query();
		int left, top, w, h, dx, dy, bw, th, step;
		logic [4:0]  flags;
		logic [95:0] data;
		bw = int'(cur_geom.frame_w);
		th = int'(cur_geom.caption_h);
		step = int'(cur_geom.btn_side) + int'(cur_geom.btn_gap);
		if ($urandom_range(0, 99) < 8) begin
			data = {$urandom, $urandom, $urandom};
			data[95:94] = 2'b00;
			flags = 5'($urandom);
			send_query(data, flags);
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				left = int'($urandom_range(0, 65535)) - 32768;
				top = int'($urandom_range(0, 65535)) - 32768;
			end else begin
				left = int'($urandom_range(0, 1000)) - 500;
				top = int'($urandom_range(0, 1000)) - 500;
			end
			case ($urandom_range(0, 19))
				0: w = 0;
				1: w = int'($urandom_range(0, 32767));
				default: w = int'($urandom_range(1, 240));
			endcase
			case ($urandom_range(0, 19))
				0: h = 0;
				1: h = int'($urandom_range(0, 32767));
				default: h = int'($urandom_range(1, 200));
			endcase
			flags[0] = $urandom_range(0, 19) != 0;
			flags[1] = $urandom_range(0, 9) < 7;
			flags[2] = $urandom_range(0, 9) < 7;
			flags[3] = $urandom_range(0, 9) < 7;
			flags[4] = $urandom_range(0, 9) < 7;
			dx = pick_offset(w, w - bw - 3 * step - 2, w - bw + 1, bw);
			dy = pick_offset(h, bw - 1, bw + th + 1, bw);
			send_offset(left, top, w, h, dx, dy, flags);
		end
	endtask

	// Hold the sender until every predicted result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// One register write; valid stays high for a following write
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value,
	                         input int width);
		logic [7:0] noise;
		noise = 8'($urandom);
		cfg_index <= idx;
		cfg_data  <= (noise << width) | value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Load a full geometry; junk sits in the unused upper data bits
	task automatic program_geometry(input geom_cfg_t g);
		write_reg(REG_FRAME_W, {4'b0, g.frame_w}, 4);
		write_reg(REG_CAPTION_H, {2'b0, g.caption_h}, 6);
		write_reg(REG_UNUSED, 8'hA5, 0);
		write_reg(REG_BTN_SIDE, {2'b0, g.btn_side}, 6);
		write_reg(REG_BTN_GAP, {4'b0, g.btn_gap}, 4);
		cfg_valid <= 1'b0;
		cur_geom = g;
	endtask

	// Directed queries under the reset geometry (4, 24, 16, 4)
	task automatic run_directed();
		// No window, empty window, points just outside
		send_offset(100, 50, 200, 150, 100, 100, FL_ALL & ~FL_VALID);
		send_offset(100, 50, 0, 150, 0, 0, FL_ALL);
		send_offset(100, 50, 200, 0, 0, 0, FL_ALL);
		send_offset(100, 50, 200, 150, -1, 80, FL_ALL);
		send_offset(100, 50, 200, 150, 200, 80, FL_ALL);
		send_offset(100, 50, 200, 150, 80, 150, FL_ALL);
		// Client, caption and the three buttons
		send_offset(100, 50, 200, 150, 100, 100, FL_ALL);
		send_offset(100, 50, 200, 150, 50, 10, FL_VALID | FL_CAPTION);
		send_offset(100, 50, 200, 150, 180, 10, FL_VALID | FL_CAPTION);
		send_offset(100, 50, 200, 150, 160, 10, FL_VALID | FL_CAPTION | FL_MAXIMIZE);
		send_offset(100, 50, 200, 150, 160, 10, FL_VALID | FL_CAPTION);
		send_offset(100, 50, 200, 150, 140, 10, FL_ALL);
		// Caption rows win over the frame; no caption flag falls through
		send_offset(100, 50, 200, 150, 0, 10, FL_ALL);
		send_offset(100, 50, 200, 150, 180, 10, FL_VALID | FL_RESIZE);
		// Corners and edges of the resize frame
		send_offset(100, 50, 200, 150, 0, 0, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 199, 0, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 0, 149, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 199, 149, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 3, 80, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 196, 80, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 100, 0, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 100, 146, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 150, 0, 80, FL_VALID);
		// Frame narrower than its bands
		send_offset(100, 50, 5, 150, 2, 80, FL_VALID | FL_RESIZE);
		send_offset(100, 50, 200, 5, 100, 2, FL_VALID | FL_RESIZE);
		// Coordinate extremes
		send_offset(32767, 0, 100, 100, -65535, 5, FL_ALL);
		send_offset(-32768, -32768, 32767, 32767, 65535, 65535, FL_ALL);
		send_offset(-32768, -32768, 32767, 32767, 32766, 32766, FL_ALL);
	endtask

	// Receiver: runs of ready with random stalls between them
	initial begin
		int run_len, stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
			                                      : $urandom_range(1, 8);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		geom_cfg_t plan[7];
		int p, i;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		gapless_sender = 1'b0;
		cur_geom = {FRAME_W_RST, CAPTION_H_RST, BTN_SIDE_RST, BTN_GAP_RST};

		plan[0] = {4'd0, 6'd0, 6'd0, 4'd0};
		plan[1] = {4'd15, 6'd63, 6'd63, 4'd15};
		// Button taller than the caption by an odd amount
		plan[2] = {4'd2, 6'd9, 6'd14, 4'd3};
		plan[3] = {4'd1, 6'd20, 6'd6, 4'd1};
		plan[4] = geom_cfg_t'(20'($urandom));
		plan[5] = geom_cfg_t'(20'($urandom));
		plan[6] = {FRAME_W_RST, CAPTION_H_RST, BTN_SIDE_RST, BTN_GAP_RST};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (p = 0; p < 7; p++) begin
			wait_drained();
			program_geometry(plan[p]);
			gapless_sender = (p == 3);
			for (i = 0; i < PhaseItems; i++) begin
				if (p == 1 && i == PhaseItems / 2)
					wait_drained();
				send_random_query();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
